// ===== sv/dtn_pkg.sv =====
// Shared types, constants and calendar helpers for the datetime normalizer.
package dtn_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_BAD_TIME = 2'd2
    } t_status;

    // Divisible-by-25 test: y * inverse(25) mod 2^16 <= floor((2^16-1)/25)
    localparam logic [15:0] INV25       = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    // floor(a/60) = (a * RECIP60_W) >> 24, exact for a < 2^18
    localparam logic [18:0] RECIP60_W   = 19'd279621;
    // floor(a/60) = (a * RECIP60_N) >> 18, exact for a < 4681
    localparam logic [12:0] RECIP60_N   = 13'd4370;

    // Biased minute sum keeps floor division unsigned: 2220 = 37 * 60
    localparam logic [12:0] MIN_BIAS    = 13'd2220;
    localparam logic [5:0]  MIN_CARRY   = 6'd37;
    // hour + carry - 37 + 48, so the day step is floor(x/24) - 2
    localparam logic [6:0]  HOUR_BIAS   = 7'd11;
    localparam logic [2:0]  DAY_BIAS    = 3'd2;

    localparam logic [3:0]  MON_JAN     = 4'd1;
    localparam logic [3:0]  MON_FEB     = 4'd2;
    localparam logic [3:0]  MON_APR     = 4'd4;
    localparam logic [3:0]  MON_JUN     = 4'd6;
    localparam logic [3:0]  MON_SEP     = 4'd9;
    localparam logic [3:0]  MON_NOV     = 4'd11;
    localparam logic [3:0]  MON_DEC     = 4'd12;

    localparam logic [4:0]  HOURS_DAY   = 5'd24;
    localparam logic [5:0]  MINS_HOUR   = 6'd60;
    localparam logic [5:0]  SECS_MIN    = 6'd60;
    localparam logic [19:0] MICRO_SEC   = 20'd1000000;

    // One item as it moves down the pipe
    typedef struct packed {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [19:0]        micro;
        logic               unit;
        t_status            status;
        logic               shift;
        logic               leap;
    } t_rec;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
        logic [4:0] len;
        case (mon)
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/dtn_shift.sv =====
// Minute, hour, day and month carry pipeline for the offset shift.
module dtn_shift
    import dtn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  t_rec        i_rec,
    input  logic [11:0] i_q,
    input  logic        i_neg,
    output logic        o_vld,
    output t_rec        o_rec
);

    // stage C: biased minute sum
    logic        r_c_vld;
    t_rec        r_c_rec;
    logic [12:0] r_c_mb;
    logic [12:0] n_c_mb;

    // stage D: minute carry quotient
    logic        r_d_vld;
    t_rec        r_d_rec;
    logic [12:0] r_d_mb;
    logic [6:0]  r_d_q2;
    logic [25:0] d_prod;

    // stage E: new minute, biased hour
    logic        r_e_vld;
    t_rec        r_e_rec;
    logic [5:0]  r_e_min;
    logic [6:0]  r_e_hb;
    logic [12:0] e_rem;

    // stage F: new hour, day before month step
    logic              r_f_vld;
    t_rec              r_f_rec;
    logic [5:0]        r_f_min;
    logic [4:0]        r_f_hour;
    logic signed [6:0] r_f_day;
    logic [2:0]        f_hq;
    logic [6:0]        f_hour;

    // stage G: month step, output
    logic        r_g_vld;
    t_rec        r_g_rec;
    t_rec        n_g_rec;
    logic [3:0]  g_prev;
    logic [4:0]  g_len_prev;
    logic [4:0]  g_len_cur;
    logic signed [6:0] g_sum;

    // delta = -(offset / 60): a negative offset adds minutes
    assign n_c_mb = 13'(i_rec.minute) + MIN_BIAS + (i_neg ? 13'(i_q) : -13'(i_q));

    assign d_prod = 26'(r_c_mb) * 26'(RECIP60_N);

    assign e_rem  = r_d_mb - 13'(r_d_q2) * 13'(MINS_HOUR);

    always_comb begin
        if (r_e_hb >= 7'd96) begin
            f_hq = 3'd4;
        end else if (r_e_hb >= 7'd72) begin
            f_hq = 3'd3;
        end else if (r_e_hb >= 7'd48) begin
            f_hq = 3'd2;
        end else if (r_e_hb >= 7'd24) begin
            f_hq = 3'd1;
        end else begin
            f_hq = 3'd0;
        end
        f_hour = r_e_hb - 7'(f_hq) * 7'(HOURS_DAY);
    end

    always_comb begin
        g_prev     = (r_f_rec.month == MON_JAN) ? MON_DEC : r_f_rec.month - 4'd1;
        g_len_prev = month_len(r_f_rec.leap, g_prev);
        g_len_cur  = month_len(r_f_rec.leap, r_f_rec.month);
        g_sum      = r_f_day;
        n_g_rec    = r_f_rec;
        if (r_f_rec.shift) begin
            n_g_rec.minute = r_f_min;
            n_g_rec.hour   = r_f_hour;
            if (r_f_day < 7'sd1) begin
                // borrow into the previous month
                g_sum         = r_f_day + $signed({2'b00, g_len_prev});
                n_g_rec.month = g_prev;
                if (r_f_rec.month == MON_JAN) begin
                    n_g_rec.year = r_f_rec.year - 16'sd1;
                end
            end else if (r_f_day > $signed({2'b00, g_len_cur})) begin
                // carry into the next month
                g_sum = r_f_day - $signed({2'b00, g_len_cur});
                if (r_f_rec.month == MON_DEC) begin
                    n_g_rec.month = MON_JAN;
                    n_g_rec.year  = r_f_rec.year + 16'sd1;
                end else begin
                    n_g_rec.month = r_f_rec.month + 4'd1;
                end
            end
            n_g_rec.day = g_sum[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else begin
            r_c_vld <= i_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_rec  <= i_rec;
        r_c_mb   <= n_c_mb;

        r_d_rec  <= r_c_rec;
        r_d_mb   <= r_c_mb;
        r_d_q2   <= d_prod[24:18];

        r_e_rec  <= r_d_rec;
        r_e_min  <= e_rem[5:0];
        r_e_hb   <= 7'(r_d_rec.hour) + r_d_q2 + HOUR_BIAS;

        r_f_rec  <= r_e_rec;
        r_f_min  <= r_e_min;
        r_f_hour <= f_hour[4:0];
        r_f_day  <= $signed(7'(r_e_rec.day) + 7'(f_hq) - 7'(DAY_BIAS));

        r_g_rec  <= n_g_rec;
    end

    assign o_vld = r_g_vld;
    assign o_rec = r_g_rec;

endmodule

// ===== sv/datetime_validate_tz_normalize_top.sv =====
// Top level: Gregorian date/time check and UTC offset normalization.
// Each request passes stages A and B here and C to G in dtn_shift; o_valid comes from stage G.
// Throughput: one request per cycle; busy is only high during reset.
// Seven register stages, set by the two reciprocal multiplies and carry chain.
// Reset: synchronous, active low; clears valid bits and apply_offset.
module datetime_validate_tz_normalize_top
    import dtn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic [13:0]        i_in_year,
    input  logic [3:0]         i_in_month,
    input  logic [4:0]         i_in_day,
    input  logic               i_has_time,
    input  logic [4:0]         i_in_hour,
    input  logic [5:0]         i_in_minute,
    input  logic [5:0]         i_in_second,
    input  logic [19:0]        i_in_micro,
    input  logic               i_has_offset,
    input  logic signed [17:0] i_offset_seconds,
    // config write channel (apply_offset)
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,
    // result, one-cycle strobe
    output logic               o_valid,
    output logic signed [15:0] o_out_year,
    output logic [3:0]         o_out_month,
    output logic [4:0]         o_out_day,
    output logic [4:0]         o_out_hour,
    output logic [5:0]         o_out_minute,
    output logic [5:0]         o_out_second,
    output logic [19:0]        o_out_micro,
    output logic               o_best_unit,
    output logic [1:0]         o_status
);

    logic r_apply;
    logic accept;

    // Stage A: latch request, range checks, mod-25 product, offset magnitude
    logic        r_a_vld;
    t_rec        r_a_rec;
    t_rec        n_a_rec;
    logic        r_a_has_time;
    logic        r_a_go;
    logic        r_a_mon_ok;
    logic        r_a_time_ok;
    logic [15:0] r_a_mod25;
    logic [17:0] r_a_abs;
    logic        r_a_neg;
    logic [29:0] a_prod;

    // Stage B: leap year, date check, status, offset / 60
    logic        r_b_vld;
    t_rec        r_b_rec;
    t_rec        n_b_rec;
    logic [11:0] r_b_q;
    logic        r_b_neg;
    logic        b_leap;
    logic [4:0]  b_len;
    logic        b_date_ok;
    logic [36:0] b_prod;

    logic        s_vld;
    t_rec        s_rec;

    // The pipe never stalls; only reset holds requests off
    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign accept      = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apply <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_apply <= i_cfg_data;
        end
    end

    // ---------------- stage A ----------------
    always_comb begin
        n_a_rec        = '0;
        n_a_rec.year   = 16'(i_in_year);
        n_a_rec.month  = i_in_month;
        n_a_rec.day    = i_in_day;
        n_a_rec.hour   = i_in_hour;
        n_a_rec.minute = i_in_minute;
        n_a_rec.second = i_in_second;
        n_a_rec.micro  = i_in_micro;
        n_a_rec.status = ST_OK;
    end

    // low half of year * inverse(25); small value means divisible by 25
    assign a_prod = 30'(i_in_year) * 30'(INV25);

    // ---------------- stage B ----------------
    // leap: divisible by 4, and not by 100 unless by 400.
    // Given divisibility by 4: by 100 <=> by 25, by 400 <=> by 25 and 16.
    assign b_leap    = (r_a_rec.year[1:0] == 2'b00) &&
                       ((r_a_mod25 > DIV25_LIMIT) || (r_a_rec.year[3:0] == 4'd0));
    assign b_len     = month_len(b_leap, r_a_rec.month);
    assign b_date_ok = r_a_mon_ok && (r_a_rec.day != 5'd0) && (r_a_rec.day <= b_len);

    // truncating offset / 60 on the magnitude
    assign b_prod    = 37'(r_a_abs) * 37'(RECIP60_W);

    always_comb begin
        n_b_rec      = r_a_rec;
        n_b_rec.leap = b_leap;
        if (!b_date_ok) begin
            // bad date: time never read
            n_b_rec.status = ST_BAD_DATE;
            n_b_rec.hour   = '0;
            n_b_rec.minute = '0;
            n_b_rec.second = '0;
            n_b_rec.micro  = '0;
        end else if (!r_a_has_time) begin
            n_b_rec.hour   = '0;
            n_b_rec.minute = '0;
            n_b_rec.second = '0;
            n_b_rec.micro  = '0;
        end else if (!r_a_time_ok) begin
            n_b_rec.status = ST_BAD_TIME;
        end else begin
            n_b_rec.unit  = 1'b1;
            n_b_rec.shift = r_a_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= accept;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_rec      <= n_a_rec;
        r_a_has_time <= i_has_time;
        r_a_go       <= r_apply & i_has_offset;
        r_a_mon_ok   <= (i_in_month >= MON_JAN) && (i_in_month <= MON_DEC);
        r_a_time_ok  <= (i_in_hour < HOURS_DAY) && (i_in_minute < MINS_HOUR) &&
                        (i_in_second < SECS_MIN) && (i_in_micro < MICRO_SEC);
        r_a_mod25    <= a_prod[15:0];
        r_a_abs      <= i_offset_seconds[17] ? 18'(-i_offset_seconds)
                                             : 18'(i_offset_seconds);
        r_a_neg      <= i_offset_seconds[17];

        r_b_rec      <= n_b_rec;
        r_b_q        <= b_prod[35:24];
        r_b_neg      <= r_a_neg;
    end

    // ---------------- stages C to G ----------------
    dtn_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_b_vld),
        .i_rec   (r_b_rec),
        .i_q     (r_b_q),
        .i_neg   (r_b_neg),
        .o_vld   (s_vld),
        .o_rec   (s_rec)
    );

    assign o_valid      = s_vld;
    assign o_out_year   = s_rec.year;
    assign o_out_month  = s_rec.month;
    assign o_out_day    = s_rec.day;
    assign o_out_hour   = s_rec.hour;
    assign o_out_minute = s_rec.minute;
    assign o_out_second = s_rec.second;
    assign o_out_micro  = s_rec.micro;
    assign o_best_unit  = s_rec.unit;
    assign o_status     = s_rec.status;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the Gregorian date/time check and UTC offset normalizer.
`timescale 1ns / 1ps

module tb_top;
    import dtn_pkg::*;

    localparam int SETTLE_CYCLES = 12;     // pipe is 7 deep; margin before a config write
    localparam int DRAIN_CYCLES  = 16;     // wait after the last result
    localparam int LIMIT_CYCLES  = 200000; // bound for the hang guard
    localparam int MAX_REPORTS   = 10;

    // One request as the sender sees it
    typedef struct packed {
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic               has_time;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [19:0]        micro;
        logic               has_offset;
        logic signed [17:0] offset;
    } t_stamp;

    // One normalized result
    typedef struct packed {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [19:0]        micro;
        logic               unit;
        t_status            status;
    } t_utc;

    typedef enum logic {
        ENT_STAMP = 1'b0,
        ENT_SHIFT_CFG = 1'b1
    } t_entry_kind;

    typedef struct {
        t_entry_kind kind;
        t_stamp      stamp;
        logic        shift_on;
    } t_entry;

    // DUT ports; every input starts at a known value
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [13:0]        i_in_year = '0;
    logic [3:0]         i_in_month = '0;
    logic [4:0]         i_in_day = '0;
    logic               i_has_time = 1'b0;
    logic [4:0]         i_in_hour = '0;
    logic [5:0]         i_in_minute = '0;
    logic [5:0]         i_in_second = '0;
    logic [19:0]        i_in_micro = '0;
    logic               i_has_offset = 1'b0;
    logic signed [17:0] i_offset_seconds = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_data = 1'b0;
    logic               o_valid;
    logic signed [15:0] o_out_year;
    logic [3:0]         o_out_month;
    logic [4:0]         o_out_day;
    logic [4:0]         o_out_hour;
    logic [5:0]         o_out_minute;
    logic [5:0]         o_out_second;
    logic [19:0]        o_out_micro;
    logic               o_best_unit;
    logic [1:0]         o_status;

    // Sender side
    t_entry stamps_to_send[$];
    t_stamp cur_stamp;
    logic   shift_cfg = 1'b0;   // shadow of apply_offset
    int     stamps_sent = 0;
    int     gap_left = 0;
    int     quiet_cycles = 0;
    bit     no_idle = 1'b0;

    // Receiver side
    t_utc   utc_due[$];
    int     stamps_checked = 0;
    int     fail_count = 0;
    int     cycles = 0;

    datetime_validate_tz_normalize_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_in_year        (i_in_year),
        .i_in_month       (i_in_month),
        .i_in_day         (i_in_day),
        .i_has_time       (i_has_time),
        .i_in_hour        (i_in_hour),
        .i_in_minute      (i_in_minute),
        .i_in_second      (i_in_second),
        .i_in_micro       (i_in_micro),
        .i_has_offset     (i_has_offset),
        .i_offset_seconds (i_offset_seconds),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_out_year       (o_out_year),
        .o_out_month      (o_out_month),
        .o_out_day        (o_out_day),
        .o_out_hour       (o_out_hour),
        .o_out_minute     (o_out_minute),
        .o_out_second     (o_out_second),
        .o_out_micro      (o_out_micro),
        .o_best_unit      (o_best_unit),
        .o_status         (o_status)
    );

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    // Leap rule of 4, 100 and 400; year -1 falls out as common
    function automatic bit is_leap(input int y);
        return ((y & 3) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
    endfunction

    function automatic int days_in(input bit leap, input int mon);
        int n;
        case (mon)
            2:             n = leap ? 29 : 28;
            4, 6, 9, 11:   n = 30;
            default:       n = 31;
        endcase
        return n;
    endfunction

    // Validate, then move the date/time to UTC when the shift is enabled and an offset is flagged
    function automatic t_utc normalize_utc(input t_stamp s, input logic shift_en);
        t_utc r;
        int   yr, mo, dy, hr, mi, sc, us;
        int   dmin, carry;
        yr = s.year;
        mo = s.month;
        dy = s.day;
        hr = 0;
        mi = 0;
        sc = 0;
        us = 0;
        r.unit = 1'b0;
        r.status = ST_OK;
        if (mo < 1 || mo > 12 || dy < 1 || dy > days_in(is_leap(yr), mo)) begin
            r.status = ST_BAD_DATE;
        end else if (s.has_time) begin
            hr = s.hour;
            mi = s.minute;
            sc = s.second;
            us = s.micro;
            if (hr >= 24 || mi >= 60 || sc >= 60 || us >= 1000000) begin
                r.status = ST_BAD_TIME;
            end else begin
                if (shift_en && s.has_offset) begin
                    // offset truncates toward zero to whole minutes, then is subtracted
                    dmin = -(int'(s.offset) / 60);
                    mi = mi + dmin;
                    carry = (mi >= 0) ? mi / 60 : -((59 - mi) / 60);
                    mi = mi - 60 * carry;
                    hr = hr + carry;
                    carry = (hr >= 0) ? hr / 24 : -((23 - hr) / 24);
                    hr = hr - 24 * carry;
                    dy = dy + carry;
                    // at most one month step either way
                    if (dy < 1) begin
                        mo = mo - 1;
                        if (mo < 1) begin
                            yr = yr - 1;
                            mo = 12;
                        end
                        dy = dy + days_in(is_leap(yr), mo);
                    end else if (dy > days_in(is_leap(yr), mo)) begin
                        dy = dy - days_in(is_leap(yr), mo);
                        mo = mo + 1;
                        if (mo > 12) begin
                            yr = yr + 1;
                            mo = 1;
                        end
                    end
                end
                r.unit = 1'b1;
            end
        end
        r.year   = yr[15:0];
        r.month  = mo[3:0];
        r.day    = dy[4:0];
        r.hour   = hr[4:0];
        r.minute = mi[5:0];
        r.second = sc[5:0];
        r.micro  = us[19:0];
        return r;
    endfunction

    function automatic string fmt_utc(input t_utc u);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d.%0d unit=%0d status=%0d",
                         u.year, u.month, u.day, u.hour, u.minute, u.second,
                         u.micro, u.unit, u.status);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    function automatic t_stamp mk(input logic [13:0] y, input logic [3:0] mo,
                                  input logic [4:0] d, input logic ht,
                                  input logic [4:0] h, input logic [5:0] mi,
                                  input logic [5:0] sc, input logic [19:0] us,
                                  input logic ho, input int off);
        t_stamp s;
        s.year = y;
        s.month = mo;
        s.day = d;
        s.has_time = ht;
        s.hour = h;
        s.minute = mi;
        s.second = sc;
        s.micro = us;
        s.has_offset = ho;
        s.offset = off[17:0];
        return s;
    endfunction

    task automatic push_stamp(input t_stamp s);
        t_entry e;
        e.kind = ENT_STAMP;
        e.stamp = s;
        e.shift_on = 1'b0;
        stamps_to_send.push_back(e);
    endtask

    task automatic push_shift_cfg(input logic on);
        t_entry e;
        e.kind = ENT_SHIFT_CFG;
        e.stamp = '0;
        e.shift_on = on;
        stamps_to_send.push_back(e);
    endtask

    // Mostly well-formed timestamps with offsets; the rest noise or bad time
    task automatic push_random(input int n);
        t_stamp s;
        int     sel, len, off;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            case ($urandom_range(0, 5))
                0:       s.year = $urandom_range(0, 1) ? 14'd16383 : 14'd0;
                1:       s.year = 14'($urandom_range(0, 163) * 100);
                2:       s.year = 14'($urandom_range(0, 4095) * 4);
                default: s.year = 14'($urandom_range(0, 16383));
            endcase
            if (sel < 12) begin
                // raw noise over every field but the year
                s.month      = 4'($urandom);
                s.day        = 5'($urandom);
                s.has_time   = 1'($urandom);
                s.hour       = 5'($urandom);
                s.minute     = 6'($urandom);
                s.second     = 6'($urandom);
                s.micro      = 20'($urandom);
                s.has_offset = 1'($urandom);
                s.offset     = 18'($urandom);
            end else begin
                s.month = 4'($urandom_range(1, 12));
                len = days_in(is_leap(s.year), s.month);
                case ($urandom_range(0, 3))
                    0:       s.day = 5'd1;
                    1:       s.day = 5'(len);
                    default: s.day = 5'($urandom_range(1, len));
                endcase
                s.has_time = (sel >= 20);
                if (sel < 28) begin
                    // time fields over their whole range, which may fall out of bounds
                    s.hour   = 5'($urandom);
                    s.minute = 6'($urandom);
                    s.second = 6'($urandom);
                    s.micro  = 20'($urandom);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       s.hour = 5'd0;
                        1:       s.hour = 5'd23;
                        default: s.hour = 5'($urandom_range(0, 23));
                    endcase
                    case ($urandom_range(0, 3))
                        0:       s.minute = 6'd0;
                        1:       s.minute = 6'd59;
                        default: s.minute = 6'($urandom_range(0, 59));
                    endcase
                    s.second = 6'($urandom_range(0, 59));
                    s.micro  = $urandom_range(0, 3) == 0 ? 20'd999999
                                                         : 20'($urandom_range(0, 999999));
                end
                s.has_offset = ($urandom_range(0, 9) != 0);
                case ($urandom_range(0, 3))
                    0:       off = int'($urandom_range(0, 262143)) - 131072;
                    1:       off = int'($urandom_range(0, 2878)) - 1439;
                    2:       off = (int'($urandom_range(0, 2878)) - 1439) * 60;
                    default: off = int'($urandom_range(0, 172798)) - 86399;
                endcase
                s.offset = off[17:0];
            end
            push_stamp(s);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Driver: presents requests and config writes from stamps_to_send.
    // Config writes wait until the pipe has been empty for a while.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : p_drive
        t_entry nxt;
        logic   start_d;
        logic   cfgv_d;
        start_d = start;
        cfgv_d = i_cfg_valid;
        if (!i_rst_n) begin
            start_d = 1'b0;
            cfgv_d = 1'b0;
            gap_left = 0;
            quiet_cycles = 0;
        end else begin
            // request taken at this edge: predict with the current setting
            if (start && !busy) begin
                utc_due.push_back(normalize_utc(cur_stamp, shift_cfg));
                stamps_sent++;
                start_d = 1'b0;
                if ($urandom_range(0, 99) == 0) begin
                    no_idle = !no_idle;
                end
                gap_left = no_idle ? 0 : $urandom_range(0, 11);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                shift_cfg = i_cfg_data;
                cfgv_d = 1'b0;
            end
            quiet_cycles = (stamps_sent == stamps_checked) ? quiet_cycles + 1 : 0;
            if (!start_d && !cfgv_d) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stamps_to_send.size() > 0) begin
                    if (stamps_to_send[0].kind == ENT_SHIFT_CFG) begin
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            nxt = stamps_to_send.pop_front();
                            i_cfg_data <= nxt.shift_on;
                            cfgv_d = 1'b1;
                        end
                    end else begin
                        nxt = stamps_to_send.pop_front();
                        cur_stamp = nxt.stamp;
                        i_in_year        <= nxt.stamp.year;
                        i_in_month       <= nxt.stamp.month;
                        i_in_day         <= nxt.stamp.day;
                        i_has_time       <= nxt.stamp.has_time;
                        i_in_hour        <= nxt.stamp.hour;
                        i_in_minute      <= nxt.stamp.minute;
                        i_in_second      <= nxt.stamp.second;
                        i_in_micro       <= nxt.stamp.micro;
                        i_has_offset     <= nxt.stamp.has_offset;
                        i_offset_seconds <= nxt.stamp.offset;
                        start_d = 1'b1;
                    end
                end
            end
        end
        start <= start_d;
        i_cfg_valid <= cfgv_d;
    end

    // ------------------------------------------------------------------
    // Monitor: every strobed result is checked against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : p_check
        t_utc got;
        t_utc want;
        if (i_rst_n && o_valid) begin
            got.year   = o_out_year;
            got.month  = o_out_month;
            got.day    = o_out_day;
            got.hour   = o_out_hour;
            got.minute = o_out_minute;
            got.second = o_out_second;
            got.micro  = o_out_micro;
            got.unit   = o_best_unit;
            got.status = t_status'(o_status);
            if (utc_due.size() == 0) begin
                if (fail_count < MAX_REPORTS) begin
                    $display("%0t: result with nothing expected: %s", $realtime, fmt_utc(got));
                end
                fail_count++;
            end else begin
                want = utc_due.pop_front();
                if (got.year !== want.year || got.month !== want.month ||
                    got.day !== want.day || got.hour !== want.hour ||
                    got.minute !== want.minute || got.second !== want.second ||
                    got.micro !== want.micro || got.unit !== want.unit ||
                    got.status !== want.status) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("%0t: result %0d mismatch", $realtime, stamps_checked);
                        $display("    expected %s", fmt_utc(want));
                        $display("    actual   %s", fmt_utc(got));
                    end
                    fail_count++;
                end
            end
            stamps_checked <= stamps_checked + 1;
        end
    end

    // Hang guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("datetime_validate_tz_normalize_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // Shift off: the offset must be ignored
        push_shift_cfg(1'b0);
        push_stamp(mk(14'd2024, 4'd2, 5'd29, 1'b1, 5'd12, 6'd0, 6'd0, 20'd0, 1'b1, 3600));
        push_stamp(mk(14'd0, 4'd0, 5'd0, 1'b0, 5'd0, 6'd0, 6'd0, 20'd0, 1'b0, 0));

        // Shift on: directed corners
        push_shift_cfg(1'b1);
        // year 0 borrows into year -1, December
        push_stamp(mk(14'd0, 4'd1, 5'd1, 1'b1, 5'd0, 6'd0, 6'd0, 20'd0, 1'b1, 60));
        // top year carries into 16384
        push_stamp(mk(14'd16383, 4'd12, 5'd31, 1'b1, 5'd23, 6'd59, 6'd59, 20'd999999,
                      1'b1, -60));
        // century rules and leap days
        push_stamp(mk(14'd2000, 4'd2, 5'd29, 1'b1, 5'd1, 6'd2, 6'd3, 20'd4, 1'b1, -131072));
        push_stamp(mk(14'd1900, 4'd2, 5'd29, 1'b1, 5'd1, 6'd2, 6'd3, 20'd4, 1'b1, 60));
        push_stamp(mk(14'd2004, 4'd2, 5'd29, 1'b0, 5'd9, 6'd9, 6'd9, 20'd9, 1'b1, 7200));
        push_stamp(mk(14'd2023, 4'd2, 5'd29, 1'b1, 5'd0, 6'd0, 6'd0, 20'd0, 1'b0, 0));
        // bad month / day
        push_stamp(mk(14'd2023, 4'd4, 5'd31, 1'b1, 5'd5, 6'd5, 6'd5, 20'd5, 1'b1, 0));
        push_stamp(mk(14'd2023, 4'd13, 5'd1, 1'b1, 5'd5, 6'd5, 6'd5, 20'd5, 1'b1, 0));
        push_stamp(mk(14'd2023, 4'd6, 5'd0, 1'b1, 5'd5, 6'd5, 6'd5, 20'd5, 1'b1, 0));
        // each time field just out of range
        push_stamp(mk(14'd2023, 4'd7, 5'd4, 1'b1, 5'd24, 6'd0, 6'd0, 20'd0, 1'b1, 600));
        push_stamp(mk(14'd2023, 4'd7, 5'd4, 1'b1, 5'd0, 6'd60, 6'd0, 20'd0, 1'b1, 600));
        push_stamp(mk(14'd2023, 4'd7, 5'd4, 1'b1, 5'd0, 6'd0, 6'd60, 20'd0, 1'b1, 600));
        push_stamp(mk(14'd2023, 4'd7, 5'd4, 1'b1, 5'd0, 6'd0, 6'd0, 20'd1000000, 1'b1, 600));
        // offsets beyond a day, across February in common and leap years
        push_stamp(mk(14'd2023, 4'd3, 5'd1, 1'b1, 5'd0, 6'd0, 6'd0, 20'd0, 1'b1, 131071));
        push_stamp(mk(14'd2024, 4'd3, 5'd1, 1'b1, 5'd0, 6'd0, 6'd0, 20'd0, 1'b1, 131071));
        push_stamp(mk(14'd2023, 4'd2, 5'd28, 1'b1, 5'd23, 6'd59, 6'd0, 20'd0, 1'b1, -131072));
        // offsets that are not whole minutes truncate toward zero
        push_stamp(mk(14'd2023, 4'd5, 5'd5, 1'b1, 5'd10, 6'd30, 6'd0, 20'd0, 1'b1, -59));
        push_stamp(mk(14'd2023, 4'd5, 5'd5, 1'b1, 5'd10, 6'd30, 6'd0, 20'd0, 1'b1, 119));
        // offset present in the field but not flagged
        push_stamp(mk(14'd2023, 4'd5, 5'd5, 1'b1, 5'd10, 6'd30, 6'd0, 20'd0, 1'b0, 3600));
        // all ones
        push_stamp(mk(14'd16383, 4'd15, 5'd31, 1'b1, 5'd31, 6'd63, 6'd63, 20'd1048575,
                      1'b1, -1));
        push_stamp(mk(14'd2023, 4'd12, 5'd31, 1'b1, 5'd23, 6'd59, 6'd59, 20'd999999,
                      1'b1, -86399));

        // Random phases, alternating the shift setting
        push_random(500);
        push_shift_cfg(1'b0);
        push_random(350);
        push_shift_cfg(1'b1);
        push_random(750);

        // Reset, once
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All requests and writes taken, then all results back
        while (stamps_to_send.size() != 0 || start || i_cfg_valid) begin
            @(negedge i_clk);
        end
        while (stamps_checked != stamps_sent) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (utc_due.size() != 0) begin
            $display("%0d expected results never arrived", utc_due.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("datetime_validate_tz_normalize_top regression: pass");
        end else begin
            $display("datetime_validate_tz_normalize_top regression: fail");
        end
        $finish;
    end

endmodule
